// ===== rtl/hnfp_pkg.sv =====
// Home network frame parser: shared types and constants.
// Phase encoding, record kinds, status codes and the result record.
// No dependencies.
`default_nettype none
package hnfp_pkg;

  typedef enum logic [3:0] {
    PH_HDR1     = 4'd0,
    PH_HDR2     = 4'd1,
    PH_TID_SPEC = 4'd2,
    PH_SRC_OBJ  = 4'd3,
    PH_DST_OBJ  = 4'd4,
    PH_SVC      = 4'd5,
    PH_COUNT    = 4'd6,
    PH_CODE     = 4'd7,
    PH_LEN      = 4'd8,
    PH_DATA     = 4'd9,
    PH_TID_FREE = 4'd10
  } phase_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PROP   = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_HDR = 2'd1;
  localparam logic [1:0] STATUS_TRUNC   = 2'd2;
  localparam logic [1:0] STATUS_ZERO    = 2'd3;

  localparam logic [7:0] HDR1_CLASS_MASK = 8'hF0;
  localparam logic [7:0] HDR1_CLASS      = 8'h10;
  localparam logic [7:0] HDR1_TOP        = 8'h80;
  localparam logic [7:0] FMT_SPEC        = 8'h81;
  localparam logic [7:0] FMT_FREE        = 8'h82;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [15:0] trans_id;
    logic [23:0] source_object;
    logic [23:0] dest_object;
    logic [7:0]  service_code;
    logic [7:0]  prop_total;
    logic [7:0]  prop_code;
    logic [7:0]  prop_length;
    logic [7:0]  data_value;
    logic [7:0]  prop_number;
    logic [1:0]  frame_status;
    logic        frame_done;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/hnfp_core.sv =====
// Home network frame parser: per-byte parse state and record builder.
// Advances one byte per step_en; result record is combinational.
// Depends on hnfp_pkg.
`default_nettype none
module hnfp_core
  import hnfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    step_en,
  input  wire logic [7:0] beat_byte,
  input  wire logic    beat_end,
  output logic         rec_emit,
  output result_t      rec
);

  phase_t      phase_r, phase_nxt, phase_step;
  logic [1:0]  fbi_r, fbi_nxt;
  logic [15:0] tid_r, tid_nxt;
  logic [23:0] src_r, src_nxt;
  logic [23:0] dst_r, dst_nxt;
  logic [7:0]  svc_r, svc_nxt;
  logic [7:0]  announced_r, announced_nxt;
  logic [7:0]  finished_r, finished_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  length_r, length_nxt;
  logic        discard_r, discard_nxt;

  logic        emit, done, hdr;
  logic [1:0]  kind, status;
  logic [7:0]  dval, pnum;
  logic [7:0]  len_eff, fin_inc;
  logic [23:0] obj_ins;

  always_comb begin
    case (fbi_r)
      2'd0:    obj_ins = {16'h0000, beat_byte};
      2'd1:    obj_ins = {8'h00, beat_byte, 8'h00};
      default: obj_ins = {beat_byte, 16'h0000};
    endcase
    len_eff = (code_r != 8'd0) ? beat_byte : 8'd0;
    fin_inc = finished_r + 8'd1;
  end

  // next state
  always_comb begin
    phase_step    = phase_r;
    fbi_nxt       = fbi_r;
    tid_nxt       = tid_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    svc_nxt       = svc_r;
    announced_nxt = announced_r;
    finished_nxt  = finished_r;
    code_nxt      = code_r;
    left_nxt      = left_r;
    length_nxt    = length_r;
    discard_nxt   = discard_r;
    emit          = 1'b0;
    done          = 1'b0;
    kind          = KIND_HEADER;
    status        = STATUS_OK;
    dval          = 8'd0;
    pnum          = finished_r;
    if (discard_r) begin
      if (beat_end) begin
        discard_nxt = 1'b0;
        phase_step  = PH_HDR1;
        fbi_nxt     = 2'd0;
      end
    end else begin
      case (phase_r)
        PH_HDR1: begin
          fbi_nxt       = 2'd0;
          tid_nxt       = 16'd0;
          src_nxt       = 24'd0;
          dst_nxt       = 24'd0;
          svc_nxt       = 8'd0;
          announced_nxt = 8'd0;
          finished_nxt  = 8'd0;
          code_nxt      = 8'd0;
          left_nxt      = 8'd0;
          length_nxt    = 8'd0;
          pnum          = 8'd0;
          if (((beat_byte & HDR1_CLASS_MASK) != HDR1_CLASS) &&
              ((beat_byte & HDR1_TOP) != HDR1_TOP)) begin
            emit   = 1'b1;
            kind   = KIND_STATUS;
            status = STATUS_BAD_HDR;
            done   = 1'b1;
          end else begin
            phase_step = PH_HDR2;
          end
        end
        PH_HDR2: begin
          fbi_nxt = 2'd0;
          if (beat_byte == FMT_SPEC) begin
            phase_step = PH_TID_SPEC;
          end else if (beat_byte == FMT_FREE) begin
            phase_step = PH_TID_FREE;
          end else begin
            emit   = 1'b1;
            kind   = KIND_STATUS;
            status = STATUS_BAD_HDR;
            done   = 1'b1;
          end
        end
        PH_TID_SPEC, PH_TID_FREE: begin
          tid_nxt = tid_r | (fbi_r[0] ? {beat_byte, 8'h00} : {8'h00, beat_byte});
          if (fbi_r != 2'd0) begin
            fbi_nxt = 2'd0;
            if (phase_r == PH_TID_FREE) begin
              emit = 1'b1;
              kind = KIND_HEADER;
              done = 1'b1;
            end else begin
              phase_step = PH_SRC_OBJ;
            end
          end else begin
            fbi_nxt = fbi_r + 2'd1;
          end
        end
        PH_SRC_OBJ, PH_DST_OBJ: begin
          if (phase_r == PH_SRC_OBJ) begin
            src_nxt = src_r | obj_ins;
          end else begin
            dst_nxt = dst_r | obj_ins;
          end
          if (fbi_r >= 2'd2) begin
            fbi_nxt    = 2'd0;
            phase_step = (phase_r == PH_SRC_OBJ) ? PH_DST_OBJ : PH_SVC;
          end else begin
            fbi_nxt = fbi_r + 2'd1;
          end
        end
        PH_SVC: begin
          svc_nxt    = beat_byte;
          phase_step = PH_COUNT;
        end
        PH_COUNT: begin
          announced_nxt = beat_byte;
          emit          = 1'b1;
          kind          = KIND_HEADER;
          if (beat_byte == 8'd0) begin
            status = STATUS_ZERO;
            done   = 1'b1;
          end else begin
            phase_step = PH_CODE;
          end
        end
        PH_CODE: begin
          code_nxt   = beat_byte;
          length_nxt = 8'd0;
          phase_step = PH_LEN;
        end
        PH_LEN: begin
          length_nxt = len_eff;
          emit       = 1'b1;
          kind       = KIND_PROP;
          if (len_eff == 8'd0) begin
            finished_nxt = fin_inc;
            if (fin_inc == announced_r) begin
              done = 1'b1;
            end else begin
              phase_step = PH_CODE;
            end
          end else begin
            left_nxt   = len_eff;
            phase_step = PH_DATA;
          end
        end
        PH_DATA: begin
          emit     = 1'b1;
          kind     = KIND_DATA;
          dval     = beat_byte;
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            finished_nxt = fin_inc;
            if (fin_inc == announced_r) begin
              done = 1'b1;
            end else begin
              phase_step = PH_CODE;
            end
          end
        end
        default: begin
          phase_step = PH_HDR1;
        end
      endcase
      if (beat_end) begin
        if (!emit) begin
          emit   = 1'b1;
          kind   = KIND_STATUS;
          status = STATUS_TRUNC;
          done   = 1'b1;
        end else if (!done) begin
          status = STATUS_TRUNC;
          done   = 1'b1;
        end
      end
    end
    phase_nxt = phase_step;
    if (!discard_r && (beat_end || done)) begin
      phase_nxt   = PH_HDR1;
      fbi_nxt     = 2'd0;
      discard_nxt = !beat_end;
    end
  end

  // record build
  always_comb begin
    hdr               = (kind == KIND_HEADER) ||
                        ((phase_step <= PH_COUNT) && (kind == KIND_STATUS));
    rec_emit          = emit;
    rec.item_kind     = kind;
    rec.trans_id      = tid_nxt;
    rec.source_object = src_nxt;
    rec.dest_object   = dst_nxt;
    rec.service_code  = svc_nxt;
    rec.prop_total    = announced_nxt;
    rec.prop_code     = hdr ? 8'd0 : code_nxt;
    rec.prop_length   = hdr ? 8'd0 : length_nxt;
    rec.data_value    = dval;
    rec.prop_number   = hdr ? 8'd0 : pnum;
    rec.frame_status  = status;
    rec.frame_done    = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR1;
      fbi_r       <= 2'd0;
      tid_r       <= 16'd0;
      src_r       <= 24'd0;
      dst_r       <= 24'd0;
      svc_r       <= 8'd0;
      announced_r <= 8'd0;
      finished_r  <= 8'd0;
      code_r      <= 8'd0;
      left_r      <= 8'd0;
      length_r    <= 8'd0;
      discard_r   <= 1'b0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      fbi_r       <= fbi_nxt;
      tid_r       <= tid_nxt;
      src_r       <= src_nxt;
      dst_r       <= dst_nxt;
      svc_r       <= svc_nxt;
      announced_r <= announced_nxt;
      finished_r  <= finished_nxt;
      code_r      <= code_nxt;
      left_r      <= left_nxt;
      length_r    <= length_nxt;
      discard_r   <= discard_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/home_network_frame_parser.sv =====
// Home network frame parser, top level: input beat register, parse core,
// result register. Depends on hnfp_pkg and hnfp_core.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one datagram byte per beat,
//   with in_frame_end high on the final byte. Output channel
//   (out_valid/out_ready) carries at most one record per input beat:
//   header, property start, property data byte or status only; the last
//   record of a frame has out_frame_done set with its status.
//   A record is registered in the result register when its byte leaves the input register.
//   Throughput: one byte per cycle while out_ready stays high; each byte
//   passes the parse state machine combinationally between the input
//   register and the result register.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to the first header byte.
//   When the receiver stalls, the pending record holds; one more byte is
//   taken into the input register, then in_ready drops until the record
//   is taken. Bytes that produce no record advance even while stalled.
`default_nettype none
module home_network_frame_parser
  import hnfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_frame_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_item_kind,
  output logic [15:0]      out_trans_id,
  output logic [23:0]      out_source_object,
  output logic [23:0]      out_dest_object,
  output logic [7:0]       out_service_code,
  output logic [7:0]       out_prop_total,
  output logic [7:0]       out_prop_code,
  output logic [7:0]       out_prop_length,
  output logic [7:0]       out_data_value,
  output logic [7:0]       out_prop_number,
  output logic [1:0]       out_frame_status,
  output logic             out_frame_done
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_rec_r;
  result_t    core_rec;
  logic       core_emit;
  logic       advance;
  logic       out_free;

  // an empty input stage may always load; a full one must advance
  // hold a beat that produces a record unless a record slot can open
  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && (!core_emit || out_free);
  assign in_ready = !s1_valid_r || advance;

  hnfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .beat_byte (s1_byte_r),
    .beat_end  (s1_end_r),
    .rec_emit  (core_emit),
    .rec       (core_rec)
  );

  always_comb begin
    s1_valid_nxt = in_ready ? in_valid : s1_valid_r;
    if (advance && core_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
      s1_end_r  <= in_frame_end;
    end
    if (advance && core_emit) begin
      out_rec_r <= core_rec;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_item_kind     = out_rec_r.item_kind;
  assign out_trans_id      = out_rec_r.trans_id;
  assign out_source_object = out_rec_r.source_object;
  assign out_dest_object   = out_rec_r.dest_object;
  assign out_service_code  = out_rec_r.service_code;
  assign out_prop_total    = out_rec_r.prop_total;
  assign out_prop_code     = out_rec_r.prop_code;
  assign out_prop_length   = out_rec_r.prop_length;
  assign out_data_value    = out_rec_r.data_value;
  assign out_prop_number   = out_rec_r.prop_number;
  assign out_frame_status  = out_rec_r.frame_status;
  assign out_frame_done    = out_rec_r.frame_done;

  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_status != STATUS_OK) |-> out_frame_done)
    else $error("error status without frame done");

  a_bad_hdr_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_status == STATUS_BAD_HDR) |->
      (out_item_kind == KIND_STATUS))
    else $error("bad header record is not status only");

  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_status == STATUS_ZERO) |->
      (out_item_kind == KIND_HEADER) && (out_prop_total == 8'd0))
    else $error("zero count record malformed");

  a_hdr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind == KIND_HEADER) |->
      (out_prop_code == 8'd0) && (out_prop_length == 8'd0) &&
      (out_prop_number == 8'd0) && (out_data_value == 8'd0))
    else $error("header record carries property fields");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_byte_r))
    else $error("stalled input beat lost");

endmodule
`default_nettype wire

// ===== verif/home_network_frame_parser_tb.sv =====
`timescale 1ns / 100ps
// Testbench for home_network_frame_parser: drives datagram bytes under random idling on both
// channels and checks every record against a cycle-free parser model kept alongside, or
// against a fixed record for pinned rows. Depends on hnfp_pkg and the parser RTL.
module home_network_frame_parser_tb;
  import hnfp_pkg::*;

  localparam int RUN_LIMIT     = 400000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [7:0] data_byte;
    logic       ends_frame;
    logic       pinned;
    result_t    rec;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_item_kind;
  logic [15:0] out_trans_id;
  logic [23:0] out_source_object;
  logic [23:0] out_dest_object;
  logic [7:0]  out_service_code;
  logic [7:0]  out_prop_total;
  logic [7:0]  out_prop_code;
  logic [7:0]  out_prop_length;
  logic [7:0]  out_data_value;
  logic [7:0]  out_prop_number;
  logic [1:0]  out_frame_status;
  logic        out_frame_done;

  logic        beat_pinned = 1'b0;
  result_t     beat_rec = '0;

  stim_row_t   directed_rows[$];
  result_t     expected_records[$];
  int          failures = 0;
  int          beats_sent = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  phase_t      ph;
  logic [1:0]  fidx;
  logic [15:0] tid_acc;
  logic [23:0] src_acc;
  logic [23:0] dst_acc;
  logic [7:0]  svc_acc;
  logic [7:0]  total_acc;
  logic [7:0]  finished_cnt;
  logic [7:0]  code_acc;
  logic [7:0]  len_acc;
  logic [7:0]  left_cnt;
  logic        skipping;

  home_network_frame_parser i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void clear_frame_state();
    fidx         = '0;
    tid_acc      = '0;
    src_acc      = '0;
    dst_acc      = '0;
    svc_acc      = '0;
    total_acc    = '0;
    finished_cnt = '0;
    code_acc     = '0;
    len_acc      = '0;
    left_cnt     = '0;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic e, output result_t rec);
    bit         emit;
    bit         done;
    bit         hdr;
    logic [1:0] kind;
    logic [1:0] status;
    logic [7:0] dval;
    logic [7:0] pnum;
    emit   = 1'b0;
    done   = 1'b0;
    kind   = KIND_HEADER;
    status = STATUS_OK;
    dval   = '0;
    pnum   = finished_cnt;
    rec    = '0;
    if (skipping) begin
      if (e) begin
        skipping = 1'b0;
        ph       = PH_HDR1;
        fidx     = '0;
      end
      return 1'b0;
    end
    case (ph)
      PH_HDR1: begin
        clear_frame_state();
        if ((b & HDR1_CLASS_MASK) != HDR1_CLASS && (b & HDR1_TOP) != HDR1_TOP) begin
          emit   = 1'b1;
          kind   = KIND_STATUS;
          status = STATUS_BAD_HDR;
          done   = 1'b1;
        end else begin
          ph = PH_HDR2;
        end
      end
      PH_HDR2: begin
        if (b == FMT_SPEC) begin
          ph = PH_TID_SPEC;
        end else if (b == FMT_FREE) begin
          ph = PH_TID_FREE;
        end else begin
          emit   = 1'b1;
          kind   = KIND_STATUS;
          status = STATUS_BAD_HDR;
          done   = 1'b1;
        end
        fidx = '0;
      end
      PH_TID_SPEC, PH_TID_FREE: begin
        tid_acc = tid_acc | (16'(b) << (8 * fidx));
        if (fidx >= 2'd1) begin
          fidx = '0;
          if (ph == PH_TID_FREE) begin
            emit = 1'b1;
            kind = KIND_HEADER;
            done = 1'b1;
          end else begin
            ph = PH_SRC_OBJ;
          end
        end else begin
          fidx++;
        end
      end
      PH_SRC_OBJ, PH_DST_OBJ: begin
        if (ph == PH_SRC_OBJ) src_acc = src_acc | (24'(b) << (8 * fidx));
        else dst_acc = dst_acc | (24'(b) << (8 * fidx));
        if (fidx >= 2'd2) begin
          fidx = '0;
          ph   = (ph == PH_SRC_OBJ) ? PH_DST_OBJ : PH_SVC;
        end else begin
          fidx++;
        end
      end
      PH_SVC: begin
        svc_acc = b;
        ph      = PH_COUNT;
      end
      PH_COUNT: begin
        total_acc = b;
        emit      = 1'b1;
        kind      = KIND_HEADER;
        if (b == 8'd0) begin
          status = STATUS_ZERO;
          done   = 1'b1;
        end else begin
          ph = PH_CODE;
        end
      end
      PH_CODE: begin
        code_acc = b;
        len_acc  = '0;
        ph       = PH_LEN;
      end
      PH_LEN: begin
        len_acc = (code_acc != 8'd0) ? b : 8'd0;
        emit    = 1'b1;
        kind    = KIND_PROP;
        if (len_acc == 8'd0) begin
          finished_cnt++;
          if (finished_cnt == total_acc) done = 1'b1;
          else ph = PH_CODE;
        end else begin
          left_cnt = len_acc;
          ph       = PH_DATA;
        end
      end
      PH_DATA: begin
        emit = 1'b1;
        kind = KIND_DATA;
        dval = b;
        left_cnt--;
        if (left_cnt == 8'd0) begin
          finished_cnt++;
          if (finished_cnt == total_acc) done = 1'b1;
          else ph = PH_CODE;
        end
      end
      default: ph = PH_HDR1;
    endcase

    if (e) begin
      if (!emit) begin
        emit   = 1'b1;
        kind   = KIND_STATUS;
        status = STATUS_TRUNC;
        done   = 1'b1;
      end else if (!done) begin
        status = STATUS_TRUNC;
        done   = 1'b1;
      end
    end

    hdr = (kind == KIND_HEADER) || (ph <= PH_COUNT && kind == KIND_STATUS);
    rec.item_kind     = kind;
    rec.trans_id      = tid_acc;
    rec.source_object = src_acc;
    rec.dest_object   = dst_acc;
    rec.service_code  = svc_acc;
    rec.prop_total    = total_acc;
    rec.prop_code     = hdr ? 8'd0 : code_acc;
    rec.prop_length   = hdr ? 8'd0 : len_acc;
    rec.data_value    = dval;
    rec.prop_number   = hdr ? 8'd0 : pnum;
    rec.frame_status  = status;
    rec.frame_done    = done;

    if (e) begin
      ph       = PH_HDR1;
      fidx     = '0;
      skipping = 1'b0;
    end else if (done) begin
      ph       = PH_HDR1;
      fidx     = '0;
      skipping = 1'b1;
    end
    return emit;
  endfunction

  task automatic report_mismatch(input string field, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("%0t ns: %s got %h, want %h", $time, field, got, want);
    failures++;
  endtask

  task automatic check_field(input string field, input logic [23:0] got,
                             input logic [23:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  always @(posedge clk) begin : monitor
    result_t predicted;
    result_t seen;
    result_t want;
    bit      produced;
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("home_network_frame_parser_tb: FAIL");
      $finish;
    end
    if (rst_n && in_valid && in_ready) begin
      produced = parse_byte(in_byte, in_frame_end, predicted);
      if (produced) expected_records.push_back(beat_pinned ? beat_rec : predicted);
    end
    if (rst_n && out_valid && out_ready) begin
      seen = {out_item_kind, out_trans_id, out_source_object, out_dest_object,
              out_service_code, out_prop_total, out_prop_code, out_prop_length,
              out_data_value, out_prop_number, out_frame_status, out_frame_done};
      if (expected_records.size() == 0) begin
        report_mismatch("record with nothing pending, kind", seen.item_kind, '0);
      end else begin
        want = expected_records.pop_front();
        check_field("item_kind", seen.item_kind, want.item_kind);
        check_field("trans_id", seen.trans_id, want.trans_id);
        check_field("source_object", seen.source_object, want.source_object);
        check_field("dest_object", seen.dest_object, want.dest_object);
        check_field("service_code", seen.service_code, want.service_code);
        check_field("prop_total", seen.prop_total, want.prop_total);
        check_field("prop_code", seen.prop_code, want.prop_code);
        check_field("prop_length", seen.prop_length, want.prop_length);
        check_field("data_value", seen.data_value, want.data_value);
        check_field("prop_number", seen.prop_number, want.prop_number);
        check_field("frame_status", seen.frame_status, want.frame_status);
        check_field("frame_done", seen.frame_done, want.frame_done);
      end
    end
  end

  function automatic result_t closing_record(input logic [1:0] kind, input logic [1:0] status,
                                             input logic [15:0] tid, input logic [23:0] src,
                                             input logic [23:0] dst, input logic [7:0] svc,
                                             input logic [7:0] total);
    result_t rec;
    rec               = '0;
    rec.item_kind     = kind;
    rec.trans_id      = tid;
    rec.source_object = src;
    rec.dest_object   = dst;
    rec.service_code  = svc;
    rec.prop_total    = total;
    rec.frame_status  = status;
    rec.frame_done    = 1'b1;
    return rec;
  endfunction

  function automatic void add_row(input logic [7:0] data_byte, input logic ends_frame,
                                  input logic pinned = 1'b0, input result_t rec = '0);
    directed_rows.push_back(stim_row_t'{data_byte, ends_frame, pinned, rec});
  endfunction

  task automatic send_beat(input logic [7:0] data_byte, input logic ends_frame,
                           input logic pinned, input result_t rec);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= data_byte;
    in_frame_end <= ends_frame;
    beat_pinned  <= pinned;
    beat_rec     <= rec;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_frame();
    logic [7:0]  fb[$];
    logic [7:0]  code;
    int unsigned pick;
    int unsigned n_props;
    int unsigned n_built;
    int unsigned plen;
    int unsigned cut;
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 6)) fb.push_back(8'($urandom));
    end else begin
      fb.push_back($urandom_range(1) ? {4'h1, 4'($urandom)} : {1'b1, 7'($urandom)});
      if (pick < 22) begin
        fb.push_back(FMT_FREE);
        repeat (2) fb.push_back(8'($urandom));
      end else begin
        fb.push_back(pick < 25 ? 8'($urandom) : FMT_SPEC);
        repeat (9) fb.push_back(8'($urandom));
        if (pick < 30) n_props = 0;
        else if (pick < 42) n_props = $urandom_range(1, 255);
        else n_props = $urandom_range(1, 4);
        fb.push_back(8'(n_props));
        n_built = (n_props > 6) ? 6 : n_props;
        for (int p = 0; p < n_built; p++) begin
          code = ($urandom_range(5) == 0) ? 8'h00 : 8'($urandom);
          plen = ($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(4);
          fb.push_back(code);
          fb.push_back(8'(plen));
          if (code != 8'h00) repeat (plen) fb.push_back(8'($urandom));
        end
      end
      if (pick >= 42 && pick < 52) begin
        cut = $urandom_range(1, fb.size());
        while (fb.size() > cut) void'(fb.pop_back());
      end else if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));
      end
    end
    foreach (fb[i]) send_beat(fb[i], i == fb.size() - 1, 1'b0, '0);
  endtask

  initial begin
    ph       = PH_HDR1;
    skipping = 1'b0;
    clear_frame_state();

    add_row(8'h00, 1'b1, 1'b1, closing_record(KIND_STATUS, STATUS_BAD_HDR, '0, '0, '0, '0, '0));
    add_row(8'h10, 1'b1, 1'b1, closing_record(KIND_STATUS, STATUS_TRUNC, '0, '0, '0, '0, '0));
    add_row(8'h90, 1'b0);
    add_row(8'h80, 1'b1, 1'b1, closing_record(KIND_STATUS, STATUS_BAD_HDR, '0, '0, '0, '0, '0));
    add_row(8'h1A, 1'b0);
    add_row(FMT_FREE, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0, 1'b1,
            closing_record(KIND_HEADER, STATUS_OK, 16'hFFFF, '0, '0, '0, '0));
    add_row(8'h55, 1'b1);
    add_row(8'h10, 1'b0);
    add_row(FMT_SPEC, 1'b0);
    repeat (9) add_row(8'hFF, 1'b0);
    add_row(8'h00, 1'b1, 1'b1, closing_record(KIND_HEADER, STATUS_ZERO, 16'hFFFF,
                                              24'hFFFFFF, 24'hFFFFFF, 8'hFF, 8'h00));
    add_row(8'h80, 1'b0);
    add_row(FMT_SPEC, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h03, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h80, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hFF, 1'b1);

    send_idle_pct = 25;
    recv_idle_pct = 76;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].data_byte, directed_rows[i].ends_frame,
                directed_rows[i].pinned, directed_rows[i].rec);
    while (beats_sent < 660) send_random_frame();

    wait_drained();
    send_idle_pct = 76;
    recv_idle_pct = 25;
    while (beats_sent < 1270) send_random_frame();

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (beats_sent < 1890) send_random_frame();

    wait_drained();
    if (failures == 0) $display("home_network_frame_parser_tb: PASS");
    else $display("home_network_frame_parser_tb: FAIL");
    $finish;
  end

endmodule
